>>> sv/sorted_insert_priority_queue_assert.svh
// assertion macros for the sorted insert priority queue checker
// expects clk and rst_n in the scope where a macro is used
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication, disabled in reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

>>> sv/spq_pkg.sv
// shared types and constants of the sorted insert priority queue
// no dependencies
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_W      = 16;
  localparam int PRI_W     = 8;
  localparam int OCC_W     = 5;

  // request action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INSERT,
    OP_REMOVE,
    OP_REJ_FULL,
    OP_REJ_EMPTY
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic action;
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

>>> sv/spq_datapath.sv
// request registers, sorted row of job cells and result registers
// depends on spq_pkg
module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic             in_action,
  input  logic [ID_W-1:0]  in_job_id,
  input  logic [PRI_W-1:0] in_job_priority,
  output logic             out_strobe,
  output logic [1:0]       out_status,
  output logic             out_valid,
  output logic [ID_W-1:0]  out_id,
  output logic [PRI_W-1:0] out_priority,
  output logic [OCC_W-1:0] out_occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  // captured request
  logic             act_r, act_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [PRI_W-1:0] pri_r, pri_nxt;

  // job cells, head at index 0
  logic [ID_W-1:0]  ids_r  [DEPTH];
  logic [PRI_W-1:0] pris_r [DEPTH];
  logic [ID_W-1:0]  ids_nxt  [DEPTH];
  logic [PRI_W-1:0] pris_nxt [DEPTH];
  logic [ID_W-1:0]  ins_ids  [DEPTH];
  logic [PRI_W-1:0] ins_pris [DEPTH];
  logic [ID_W-1:0]  rem_ids  [DEPTH];
  logic [PRI_W-1:0] rem_pris [DEPTH];
  logic [DEPTH-1:0] gt;

  logic [CW-1:0]    count_r, count_nxt;

  // result registers
  logic             strobe_r, strobe_nxt;
  status_t          status_r, status_nxt;
  logic             valid_r, valid_nxt;
  logic [ID_W-1:0]  oid_r, oid_nxt;
  logic [PRI_W-1:0] opri_r, opri_nxt;

  // status toward the controller
  assign stat.action = act_r;
  assign stat.full   = (count_r == CW'(DEPTH));
  assign stat.empty  = (count_r == '0);

  // per-cell compare and shift, all cells in parallel
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    // live cell holding a strictly higher priority keeps its job on insert
    assign gt[k] = (CW'(k) < count_r) && (pris_r[k] > pri_r);

    always_comb begin
      if (gt[k]) begin
        ins_ids[k]  = ids_r[k];
        ins_pris[k] = pris_r[k];
      end else if (k == 0) begin
        ins_ids[k]  = id_r;
        ins_pris[k] = pri_r;
      end else if (gt[(k == 0) ? 0 : k-1]) begin
        ins_ids[k]  = id_r;
        ins_pris[k] = pri_r;
      end else begin
        ins_ids[k]  = ids_r[(k == 0) ? 0 : k-1];
        ins_pris[k] = pris_r[(k == 0) ? 0 : k-1];
      end
    end

    // remove moves every job up by one slot
    if (k < DEPTH - 1) begin : g_up
      assign rem_ids[k]  = ids_r[k+1];
      assign rem_pris[k] = pris_r[k+1];
    end else begin : g_last
      assign rem_ids[k]  = ids_r[k];
      assign rem_pris[k] = pris_r[k];
    end
  end

  // next state of request, cells, count and result
  always_comb begin
    act_nxt    = act_r;
    id_nxt     = id_r;
    pri_nxt    = pri_r;
    ids_nxt    = ids_r;
    pris_nxt   = pris_r;
    count_nxt  = count_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    valid_nxt  = valid_r;
    oid_nxt    = oid_r;
    opri_nxt   = opri_r;
    case (cmd.op)
      OP_LOAD: begin
        act_nxt = in_action;
        id_nxt  = in_job_id;
        pri_nxt = in_job_priority;
      end
      OP_INSERT: begin
        ids_nxt    = ins_ids;
        pris_nxt   = ins_pris;
        count_nxt  = count_r + CW'(1);
        strobe_nxt = 1'b1;
        status_nxt = ST_DONE;
        valid_nxt  = 1'b0;
        oid_nxt    = '0;
        opri_nxt   = '0;
      end
      OP_REMOVE: begin
        ids_nxt    = rem_ids;
        pris_nxt   = rem_pris;
        count_nxt  = count_r - CW'(1);
        strobe_nxt = 1'b1;
        status_nxt = ST_DONE;
        valid_nxt  = 1'b1;
        oid_nxt    = ids_r[0];
        opri_nxt   = pris_r[0];
      end
      OP_REJ_FULL: begin
        strobe_nxt = 1'b1;
        status_nxt = ST_FULL;
        valid_nxt  = 1'b0;
        oid_nxt    = '0;
        opri_nxt   = '0;
      end
      OP_REJ_EMPTY: begin
        strobe_nxt = 1'b1;
        status_nxt = ST_EMPTY;
        valid_nxt  = 1'b0;
        oid_nxt    = '0;
        opri_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    id_r     <= id_nxt;
    pri_r    <= pri_nxt;
    ids_r    <= ids_nxt;
    pris_r   <= pris_nxt;
    status_r <= status_nxt;
    valid_r  <= valid_nxt;
    oid_r    <= oid_nxt;
    opri_r   <= opri_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_status    = status_r;
  assign out_valid     = valid_r;
  assign out_id        = oid_r;
  assign out_priority  = opri_r;
  assign out_occupancy = OCC_W'(count_r);

endmodule

>>> sv/spq_ctrl.sv
// controller state machine: captures a request, then picks the datapath operation
// depends on spq_pkg
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    busy      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        busy      = 1'b1;
        state_nxt = S_IDLE;
        if (stat.action == ACT_INSERT) begin
          cmd.op = stat.full ? OP_REJ_FULL : OP_INSERT;
        end else begin
          cmd.op = stat.empty ? OP_REJ_EMPTY : OP_REMOVE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/sorted_insert_priority_queue.sv
// Sorted priority queue of (id, priority) jobs, DEPTH deep, highest priority at
// the head; an insert goes ahead of stored jobs of equal or lower priority. A
// transaction is taken when start is high and busy is low. A transaction first
// captures the request; then every job cell compares its priority with the new
// job and shifts in parallel. The result is shown for exactly one cycle with
// out_strobe high, in the cycle after the busy cycle; the receiver cannot stall,
// and a new transaction may start during that strobe cycle. No clearing pass
// after reset.
// depends on spq_pkg, spq_ctrl and spq_datapath
module sorted_insert_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_action,
  input  logic [ID_W-1:0]  in_job_id,
  input  logic [PRI_W-1:0] in_job_priority,
  output logic             out_strobe,
  output logic [1:0]       out_status,
  output logic             out_valid,
  output logic [ID_W-1:0]  out_id,
  output logic [PRI_W-1:0] out_priority,
  output logic [OCC_W-1:0] out_occupancy
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller
  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_job_id       (in_job_id),
    .in_job_priority (in_job_priority),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_valid       (out_valid),
    .out_id          (out_id),
    .out_priority    (out_priority),
    .out_occupancy   (out_occupancy)
  );

endmodule

>>> sv/spq_checker.sv
// port-level checker for the sorted insert priority queue, with its bind
// depends on spq_pkg and sorted_insert_priority_queue_assert.svh
`include "sorted_insert_priority_queue_assert.svh"

module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_strobe,
  input logic [1:0]       out_status,
  input logic             out_valid,
  input logic [OCC_W-1:0] out_occupancy
);

  // accepted transaction goes busy, then gives exactly one strobe
  `SPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_strobe)
  `SPQ_ASSERT_NEXT(a_busy_strobe, busy, out_strobe && !busy)

  // a removed job always comes with done status
  `SPQ_ASSERT_NOW(a_valid_done, out_strobe && out_valid, out_status == ST_DONE)

  // rejects report the matching fill level
  `SPQ_ASSERT_NOW(a_empty_occ, out_strobe && (out_status == ST_EMPTY), out_occupancy == '0)
  `SPQ_ASSERT_NOW(a_full_occ, out_strobe && (out_status == ST_FULL),
                  out_occupancy == OCC_W'(DEPTH))

endmodule

bind sorted_insert_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
